// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared shorthand for concurrent assertions, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PFCP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pfcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcp_pkg
// types, character codes and helpers of the pixel flood command parser
// ----------------------------------------------------------------------------
package pfcp_pkg;

	localparam int unsigned COORD_W   = 13;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned COLOR_W   = 8;
	localparam int unsigned RGB_W     = 24;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned HEX_CNT_W = 3;
	localparam int unsigned NIBBLE_W  = 4;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SIZE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 13'd64;
	localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 13'd32;

	// characters
	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
	localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;
	localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h66;
	localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
	localparam logic [BYTE_W-1:0] CH_I     = 8'h49;
	localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
	localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
	localparam logic [BYTE_W-1:0] CH_X     = 8'h58;
	localparam logic [BYTE_W-1:0] CH_Z     = 8'h5A;

	// sixth colour digit is taken when the count reads this
	localparam logic [HEX_CNT_W-1:0] HEX_LAST = 3'd5;
	localparam logic [NIBBLE_W-1:0]  HEX_ALPHA_OFS = 4'd10;

	typedef enum logic [13:0] {
		PH_START   = 14'b00000000000001,
		PH_S1      = 14'b00000000000010,
		PH_S2      = 14'b00000000000100,
		PH_S3      = 14'b00000000001000,
		PH_STAIL   = 14'b00000000010000,
		PH_P1      = 14'b00000000100000,
		PH_P2      = 14'b00000001000000,
		PH_XPRE    = 14'b00000010000000,
		PH_XNUM    = 14'b00000100000000,
		PH_YPRE    = 14'b00001000000000,
		PH_YNUM    = 14'b00010000000000,
		PH_HEX     = 14'b00100000000000,
		PH_PTAIL   = 14'b01000000000000,
		PH_DISCARD = 14'b10000000000000
	} phase_t;

	typedef struct packed {
		logic              emit;
		logic [KIND_W-1:0]  kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [RGB_W-1:0]   rgb;
	} result_t;

	function automatic logic is_skip_space(input logic [BYTE_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
			(c == CH_CR);
	endfunction

	function automatic logic is_digit(input logic [BYTE_W-1:0] c);
		return c inside {[CH_0:CH_9]};
	endfunction

	function automatic logic is_hex(input logic [BYTE_W-1:0] c);
		return (c inside {[CH_0:CH_9]}) || (c inside {[CH_UA:CH_UF]}) ||
			(c inside {[CH_LA:CH_LF]});
	endfunction

	// value of a hex digit, meaningless for other bytes
	function automatic logic [NIBBLE_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
		logic [NIBBLE_W-1:0] v;
		if (c inside {[CH_0:CH_9]}) begin
			v = NIBBLE_W'(c - CH_0);
		end else if (c inside {[CH_UA:CH_UF]}) begin
			v = NIBBLE_W'(c - CH_UA) + HEX_ALPHA_OFS;
		end else begin
			v = NIBBLE_W'(c - CH_LA) + HEX_ALPHA_OFS;
		end
		return v;
	endfunction

endpackage

// ===== rtl/core/pixel_flood_command_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_flood_command_parser
// text command parser for a pixel flood display: size queries and pixel writes
// ----------------------------------------------------------------------------
// The block eats the command stream one byte per clock while in_stall is low.
// Each byte goes into an input register, the line parser updates its state
// from that register, and any result lands in the output register behind
// out_valid. Sustained rate is one byte per cycle while in_stall is low; it
// is set by the single parser stage. A byte that gives no result
// never waits for the output side, and a new byte is taken while a result
// waits to be picked up; in_stall rises only when the byte in the input
// register would give a second result while the first one is still held.
// Results: kind 0 is a pixel write (x, y, colour), kind 1 a size reply that
// carries frame_width and frame_height with colour zero, kind 2 a malformed
// or out-of-range line with all other fields zero; the rest of that line is
// dropped. Register 0 is frame_width, register 1 frame_height; writes are
// always taken and apply at once.
module pixel_flood_command_parser #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command byte channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [pfcp_pkg::BYTE_W-1:0]          data_byte,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pfcp_pkg::KIND_W-1:0]          result_kind,
	output logic [pfcp_pkg::COORD_W-1:0]         coord_x,
	output logic [pfcp_pkg::COORD_W-1:0]         coord_y,
	output logic [pfcp_pkg::COLOR_W-1:0]         red,
	output logic [pfcp_pkg::COLOR_W-1:0]         green,
	output logic [pfcp_pkg::COLOR_W-1:0]         blue,
	// register write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pfcp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pfcp_pkg::COORD_W-1:0]         cfg_data
);

	// frame size registers
	logic [pfcp_pkg::COORD_W-1:0] frame_width_q;
	logic [pfcp_pkg::COORD_W-1:0] frame_height_q;

	// input stage
	logic                         valid_s1;
	logic [pfcp_pkg::BYTE_W-1:0]  byte_s1;

	// output stage
	logic                         out_valid_q;
	pfcp_pkg::result_t            result_q;

	pfcp_pkg::result_t            res;
	logic                         advance;
	logic                         out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= pfcp_pkg::FRAME_WIDTH_RST;
			frame_height_q <= pfcp_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pfcp_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				pfcp_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output slot can take a result this cycle
	assign out_free = !out_valid_q || !out_stall;

	// the byte in the input register moves on unless its result has no slot
	assign advance  = valid_s1 && (!res.emit || out_free);

	// the input register refills whenever it empties or moves on
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	pfcp_parser #(
		.COORD_BITS(COORD_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.data_byte    (byte_s1),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.res          (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			result_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = result_q.kind;
	assign coord_x     = result_q.x;
	assign coord_y     = result_q.y;
	assign red         = result_q.rgb[3*pfcp_pkg::COLOR_W-1:2*pfcp_pkg::COLOR_W];
	assign green       = result_q.rgb[2*pfcp_pkg::COLOR_W-1:pfcp_pkg::COLOR_W];
	assign blue        = result_q.rgb[pfcp_pkg::COLOR_W-1:0];

endmodule

// ===== rtl/core/pfcp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcp_parser
// line state machine: takes one byte per step and forms at most one result
// ----------------------------------------------------------------------------
module pfcp_parser #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [pfcp_pkg::BYTE_W-1:0]        data_byte,
	input  logic [pfcp_pkg::COORD_W-1:0]       frame_width,
	input  logic [pfcp_pkg::COORD_W-1:0]       frame_height,
	output pfcp_pkg::result_t                  res
);

	localparam int unsigned ACC_W = COORD_BITS + 1;
	localparam int unsigned CMP_W = (ACC_W > pfcp_pkg::COORD_W) ? ACC_W : pfcp_pkg::COORD_W;
	localparam int unsigned MUL_W = ACC_W + 4;
	localparam logic [ACC_W-1:0] SAT_LIMIT = {1'b1, {COORD_BITS{1'b0}}};

	pfcp_pkg::phase_t                     phase_q, phase_d;
	logic [ACC_W-1:0]                     acc_q, acc_d;
	logic                                 neg_q, neg_d;
	logic                                 seen_q, seen_d;
	logic [pfcp_pkg::COORD_W-1:0]         col_q, col_d;
	logic [pfcp_pkg::RGB_W-1:0]           color_q, color_d;
	logic [pfcp_pkg::HEX_CNT_W-1:0]       hex_cnt_q, hex_cnt_d;

	logic [pfcp_pkg::NIBBLE_W-1:0]        dval;
	logic [MUL_W-1:0]                     prod;
	logic [ACC_W-1:0]                     acc_sat;
	logic [pfcp_pkg::COORD_W-1:0]         bound;
	logic                                 fits;

	// accumulator * 10 + digit, saturating
	always_comb begin
		dval    = pfcp_pkg::NIBBLE_W'(data_byte - pfcp_pkg::CH_0);
		prod    = (MUL_W'(acc_q) << 3) + (MUL_W'(acc_q) << 1) + MUL_W'(dval);
		acc_sat = (prod > MUL_W'(SAT_LIMIT)) ? SAT_LIMIT : prod[ACC_W-1:0];
	end

	// range check of the finished number
	always_comb begin
		bound = (phase_q == pfcp_pkg::PH_YNUM) ? frame_height : frame_width;
		fits  = !(neg_q && (acc_q != '0)) && (CMP_W'(acc_q) < CMP_W'(bound)) &&
			!acc_q[COORD_BITS];
	end

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		neg_d     = neg_q;
		seen_d    = seen_q;
		col_d     = col_q;
		color_d   = color_q;
		hex_cnt_d = hex_cnt_q;
		res       = '0;

		case (phase_q)
			pfcp_pkg::PH_START: begin
				if (data_byte == pfcp_pkg::CH_S) begin
					phase_d = pfcp_pkg::PH_S1;
				end else if (data_byte == pfcp_pkg::CH_P) begin
					phase_d = pfcp_pkg::PH_P1;
				end else begin
					res.emit = 1'b1;
				end
			end
			pfcp_pkg::PH_S1: begin
				if (data_byte == pfcp_pkg::CH_I) phase_d = pfcp_pkg::PH_S2;
				else res.emit = 1'b1;
			end
			pfcp_pkg::PH_S2: begin
				if (data_byte == pfcp_pkg::CH_Z) phase_d = pfcp_pkg::PH_S3;
				else res.emit = 1'b1;
			end
			pfcp_pkg::PH_S3: begin
				if (data_byte == pfcp_pkg::CH_E) phase_d = pfcp_pkg::PH_STAIL;
				else res.emit = 1'b1;
			end
			pfcp_pkg::PH_STAIL: begin
				if (data_byte == pfcp_pkg::CH_NL) begin
					phase_d  = pfcp_pkg::PH_START;
					res.emit = 1'b1;
					res.kind = pfcp_pkg::KIND_SIZE;
					res.x    = frame_width;
					res.y    = frame_height;
				end
			end
			pfcp_pkg::PH_P1: begin
				if (data_byte == pfcp_pkg::CH_X) phase_d = pfcp_pkg::PH_P2;
				else res.emit = 1'b1;
			end
			pfcp_pkg::PH_P2: begin
				if (data_byte == pfcp_pkg::CH_SPACE) phase_d = pfcp_pkg::PH_XPRE;
				else res.emit = 1'b1;
			end
			pfcp_pkg::PH_XPRE, pfcp_pkg::PH_YPRE: begin
				if (!pfcp_pkg::is_skip_space(data_byte)) begin
					acc_d  = '0;
					neg_d  = 1'b0;
					seen_d = 1'b0;
					if ((data_byte == pfcp_pkg::CH_PLUS) || (data_byte == pfcp_pkg::CH_MINUS)) begin
						neg_d   = (data_byte == pfcp_pkg::CH_MINUS);
						phase_d = (phase_q == pfcp_pkg::PH_XPRE) ? pfcp_pkg::PH_XNUM :
							pfcp_pkg::PH_YNUM;
					end else if (pfcp_pkg::is_digit(data_byte)) begin
						// a single digit is below the saturation limit when COORD_BITS is 4 or more
						acc_d   = ACC_W'(dval);
						seen_d  = 1'b1;
						phase_d = (phase_q == pfcp_pkg::PH_XPRE) ? pfcp_pkg::PH_XNUM :
							pfcp_pkg::PH_YNUM;
					end else begin
						res.emit = 1'b1;
					end
				end
			end
			pfcp_pkg::PH_XNUM, pfcp_pkg::PH_YNUM: begin
				if (pfcp_pkg::is_digit(data_byte)) begin
					acc_d  = acc_sat;
					seen_d = 1'b1;
				end else if ((data_byte == pfcp_pkg::CH_SPACE) && seen_q && fits) begin
					if (phase_q == pfcp_pkg::PH_XNUM) begin
						col_d   = pfcp_pkg::COORD_W'(acc_q);
						phase_d = pfcp_pkg::PH_YPRE;
					end else begin
						color_d   = '0;
						hex_cnt_d = '0;
						phase_d   = pfcp_pkg::PH_HEX;
					end
				end else begin
					res.emit = 1'b1;
				end
			end
			pfcp_pkg::PH_HEX: begin
				if (pfcp_pkg::is_hex(data_byte)) begin
					color_d   = {color_q[pfcp_pkg::RGB_W-pfcp_pkg::NIBBLE_W-1:0],
						pfcp_pkg::hex_value(data_byte)};
					hex_cnt_d = hex_cnt_q + 1'b1;
					if (hex_cnt_q == pfcp_pkg::HEX_LAST) phase_d = pfcp_pkg::PH_PTAIL;
				end else begin
					res.emit = 1'b1;
				end
			end
			pfcp_pkg::PH_PTAIL: begin
				if (data_byte == pfcp_pkg::CH_NL) begin
					phase_d  = pfcp_pkg::PH_START;
					res.emit = 1'b1;
					res.kind = pfcp_pkg::KIND_PIXEL;
					res.x    = col_q;
					res.y    = pfcp_pkg::COORD_W'(acc_q);
					res.rgb  = color_q;
				end
			end
			pfcp_pkg::PH_DISCARD: begin
				if (data_byte == pfcp_pkg::CH_NL) phase_d = pfcp_pkg::PH_START;
			end
			default: begin
				phase_d = pfcp_pkg::PH_START;
			end
		endcase

		// every emit left without a kind is a fault: drop the rest of the line
		if (res.emit && (res.kind == pfcp_pkg::KIND_PIXEL) &&
			(phase_q != pfcp_pkg::PH_PTAIL)) begin
			res.kind = pfcp_pkg::KIND_ERROR;
			phase_d  = (data_byte == pfcp_pkg::CH_NL) ? pfcp_pkg::PH_START :
				pfcp_pkg::PH_DISCARD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= pfcp_pkg::PH_START;
			acc_q     <= '0;
			neg_q     <= 1'b0;
			seen_q    <= 1'b0;
			col_q     <= '0;
			color_q   <= '0;
			hex_cnt_q <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			acc_q     <= acc_d;
			neg_q     <= neg_d;
			seen_q    <= seen_d;
			col_q     <= col_d;
			color_q   <= color_d;
			hex_cnt_q <= hex_cnt_d;
		end
	end

endmodule

// ===== rtl/core/pfcp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcp_checker
// port-level checks of the pixel flood command parser, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfcp_checker #(
	parameter int unsigned COORD_BITS = 12
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [pfcp_pkg::KIND_W-1:0]    result_kind,
	input logic [pfcp_pkg::COORD_W-1:0]   coord_x,
	input logic [pfcp_pkg::COORD_W-1:0]   coord_y,
	input logic [pfcp_pkg::COLOR_W-1:0]   red,
	input logic [pfcp_pkg::COLOR_W-1:0]   green,
	input logic [pfcp_pkg::COLOR_W-1:0]   blue
);

	localparam int unsigned X_LIMIT = 1 << COORD_BITS;

	// a held result stays offered
	`PFCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

	// input only backs up behind a blocked result
	`PFCP_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall && in_valid !== 1'bx, "input stalled with free output")

	// error results carry nothing else
	`PFCP_ASSERT_IMPL(a_error_clean, out_valid && (result_kind == pfcp_pkg::KIND_ERROR), (coord_x == '0) && (coord_y == '0) && (red == '0) && (green == '0) && (blue == '0), "error result with payload")

	// size replies carry no colour, pixel columns stay in coordinate range
	`PFCP_ASSERT_IMPL(a_size_dark, out_valid && (result_kind == pfcp_pkg::KIND_SIZE), (red == '0) && (green == '0) && (blue == '0), "size reply with colour")

	`PFCP_ASSERT_IMPL(a_pixel_range, out_valid && (result_kind == pfcp_pkg::KIND_PIXEL), 32'(coord_x) < X_LIMIT, "pixel column out of range")

endmodule

bind pixel_flood_command_parser pfcp_checker #(
	.COORD_BITS(COORD_BITS)
) u_pfcp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result_kind (result_kind),
	.coord_x     (coord_x),
	.coord_y     (coord_y),
	.red         (red),
	.green       (green),
	.blue        (blue)
);

// ===== bench/pfcp_parse_tracker_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfcp_parse_tracker_pkg
// line parser tracker: predicts the replies of the command parser byte by
// byte and checks the replies that come out of the block in order
// ----------------------------------------------------------------------------
package pfcp_parse_tracker_pkg;

	import pfcp_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} reply_t;

	// outcome of one byte in or before a decimal number
	typedef enum int {
		NUM_MORE,
		NUM_DONE,
		NUM_BAD
	} num_step_t;

	class parse_tracker;

		int unsigned failures;

		local int unsigned reported;
		local reply_t replies_due[$];
		local logic [COORD_W-1:0] width_reg;
		local logic [COORD_W-1:0] height_reg;
		local phase_t phase;
		local int unsigned num_val;
		local bit num_neg;
		local bit num_has_digit;
		local logic [COORD_W-1:0] column;
		local logic [RGB_W-1:0] rgb;
		local int unsigned hex_count;
		local int unsigned sat_value;

		function new(int unsigned coord_bits);
			sat_value = 1 << coord_bits;
			width_reg = FRAME_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			phase = PH_START;
			num_val = 0;
			num_neg = 0;
			num_has_digit = 0;
			column = '0;
			rgb = '0;
			hex_count = 0;
			failures = 0;
			reported = 0;
		endfunction

		function int unsigned pending();
			return replies_due.size();
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
			if (idx == REG_FRAME_WIDTH) begin
				width_reg = val;
			end else begin
				height_reg = val;
			end
		endfunction

		local function bit is_blank(logic [BYTE_W-1:0] c);
			return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
		endfunction

		local function bit is_dec(logic [BYTE_W-1:0] c);
			return c >= CH_0 && c <= CH_9;
		endfunction

		local function bit hex_ok(logic [BYTE_W-1:0] c);
			return is_dec(c) || (c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF);
		endfunction

		local function logic [3:0] hex_nibble(logic [BYTE_W-1:0] c);
			logic [BYTE_W-1:0] v;
			if (is_dec(c)) begin
				v = c - CH_0;
			end else if (c <= CH_UF) begin
				v = c - CH_UA + 8'd10;
			end else begin
				v = c - CH_LA + 8'd10;
			end
			return v[3:0];
		endfunction

		// leading blanks, optional sign, digits; a space ends the number
		local function num_step_t number_byte(logic [BYTE_W-1:0] c, bit in_num,
				phase_t num_phase);
			if (!in_num) begin
				if (is_blank(c)) return NUM_MORE;
				num_val = 0;
				num_neg = 0;
				num_has_digit = 0;
				if (c == CH_PLUS || c == CH_MINUS) begin
					num_neg = (c == CH_MINUS);
					phase = num_phase;
					return NUM_MORE;
				end
				if (!is_dec(c)) return NUM_BAD;
				phase = num_phase;
			end else if (!is_dec(c)) begin
				return (c == CH_SPACE && num_has_digit) ? NUM_DONE : NUM_BAD;
			end
			num_val = num_val * 10 + (c - CH_0);
			if (num_val > sat_value) num_val = sat_value;
			num_has_digit = 1;
			return NUM_MORE;
		endfunction

		local function bit coord_ok(logic [COORD_W-1:0] bound);
			if (num_neg && num_val != 0) return 0;
			return num_val < bound && num_val < sat_value;
		endfunction

		function void note_byte(logic [BYTE_W-1:0] c);
			reply_t r;
			num_step_t step;
			bit give;
			bit bad;
			give = 0;
			bad = 0;
			r = '0;
			case (phase)
				PH_START: begin
					if (c == CH_S) phase = PH_S1;
					else if (c == CH_P) phase = PH_P1;
					else bad = 1;
				end
				PH_S1: begin
					if (c == CH_I) phase = PH_S2;
					else bad = 1;
				end
				PH_S2: begin
					if (c == CH_Z) phase = PH_S3;
					else bad = 1;
				end
				PH_S3: begin
					if (c == CH_E) phase = PH_STAIL;
					else bad = 1;
				end
				PH_STAIL: begin
					if (c == CH_NL) begin
						phase = PH_START;
						give = 1;
						r.kind = KIND_SIZE;
						r.x = width_reg;
						r.y = height_reg;
					end
				end
				PH_P1: begin
					if (c == CH_X) phase = PH_P2;
					else bad = 1;
				end
				PH_P2: begin
					if (c == CH_SPACE) phase = PH_XPRE;
					else bad = 1;
				end
				PH_XPRE, PH_XNUM: begin
					step = number_byte(c, phase == PH_XNUM, PH_XNUM);
					if (step == NUM_BAD) begin
						bad = 1;
					end else if (step == NUM_DONE) begin
						if (!coord_ok(width_reg)) begin
							bad = 1;
						end else begin
							column = COORD_W'(num_val);
							phase = PH_YPRE;
						end
					end
				end
				PH_YPRE, PH_YNUM: begin
					step = number_byte(c, phase == PH_YNUM, PH_YNUM);
					if (step == NUM_BAD) begin
						bad = 1;
					end else if (step == NUM_DONE) begin
						if (!coord_ok(height_reg)) begin
							bad = 1;
						end else begin
							rgb = '0;
							hex_count = 0;
							phase = PH_HEX;
						end
					end
				end
				PH_HEX: begin
					if (!hex_ok(c)) begin
						bad = 1;
					end else begin
						rgb = {rgb[RGB_W-5:0], hex_nibble(c)};
						hex_count++;
						if (hex_count >= 6) phase = PH_PTAIL;
					end
				end
				PH_PTAIL: begin
					if (c == CH_NL) begin
						phase = PH_START;
						give = 1;
						r.kind = KIND_PIXEL;
						r.x = column;
						r.y = COORD_W'(num_val);
						r.red = rgb[23:16];
						r.green = rgb[15:8];
						r.blue = rgb[7:0];
					end
				end
				default: begin
					if (c == CH_NL) phase = PH_START;
				end
			endcase
			// a fault drops the rest of the line unless the fault is the newline
			if (bad) begin
				phase = (c == CH_NL) ? PH_START : PH_DISCARD;
				give = 1;
				r = '0;
				r.kind = KIND_ERROR;
			end
			if (give) begin
				replies_due = {replies_due, r};
			end
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (replies_due.size() == 0) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("unexpected reply: kind %0d x %0d y %0d rgb %02h%02h%02h",
						got.kind, got.x, got.y, got.red, got.green, got.blue);
				end
				return;
			end
			want = replies_due.pop_front();
			if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
					got.red !== want.red || got.green !== want.green ||
					got.blue !== want.blue) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("reply mismatch: want kind %0d x %0d y %0d rgb %02h%02h%02h, %s",
						want.kind, want.x, want.y, want.red, want.green, want.blue,
						$sformatf("got kind %0d x %0d y %0d rgb %02h%02h%02h",
							got.kind, got.x, got.y, got.red, got.green, got.blue));
				end
			end
		endfunction

	endclass

endpackage

// ===== bench/pixel_flood_command_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_flood_command_parser_test
// self-checking bench of the pixel flood command parser: directed lines for
// every command and fault, then random well-formed, broken and noise lines
// under several frame sizes, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module pixel_flood_command_parser_test;

	import pfcp_pkg::*;
	import pfcp_parse_tracker_pkg::*;

	localparam int unsigned COORD_BITS    = 12;
	localparam int unsigned RUN_LIMIT     = 200000;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned RUN_BYTES     = 850;
	localparam int unsigned PHASE_BYTES   = 40;

	logic clk = 1'b0;
	logic arst_n;

	logic                 in_valid;
	logic                 in_stall;
	logic [BYTE_W-1:0]    data_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [KIND_W-1:0]    result_kind;
	logic [COORD_W-1:0]   coord_x;
	logic [COORD_W-1:0]   coord_y;
	logic [COLOR_W-1:0]   red;
	logic [COLOR_W-1:0]   green;
	logic [COLOR_W-1:0]   blue;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_data;

	parse_tracker tracker;

	// bytes of the line being built, sent item by item by send_line
	logic [BYTE_W-1:0] line_buf[$];

	// frame size the stimulus aims its coordinates at
	int cur_w = 64;
	int cur_h = 32;

	// traffic shaping
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit quiet_tail = 1'b0;
	int rx_hold_req = 0;
	int hold_left = 0;
	int burst_left = 0;
	int rx_mode_left = 0;

	int unsigned bytes_taken = 0;
	int unsigned cycle_count = 0;

	pixel_flood_command_parser #(
		.COORD_BITS(COORD_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.red(red),
		.green(green),
		.blue(blue),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("pixel_flood_command_parser_test failed");
			$finish;
		end
	end

	// handshakes sampled at the edge; drivers update after it, so the
	// values seen here are the ones the block sees
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) tracker.set_register(cfg_index, cfg_data);
			if (out_valid && !out_stall) begin
				tracker.check_reply({result_kind, coord_x, coord_y, red, green, blue});
			end
			if (in_valid && !in_stall) begin
				tracker.note_byte(data_byte);
				bytes_taken++;
			end
		end
	end

	// result side: random stall bursts, calm stretches, and one long hold
	// requested by the stimulus and counted out here
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (rx_mode_left == 0) begin
				rx_calm = ($urandom_range(0, 2) == 0);
				rx_mode_left = $urandom_range(20, 120);
			end else begin
				rx_mode_left--;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (burst_left != 0) begin
				burst_left--;
				out_stall <= 1'b1;
			end else if (!rx_calm && !quiet_tail && $urandom_range(0, 4) == 0) begin
				burst_left = $urandom_range(0, 9);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// line building
	// ------------------------------------------------------------------

	// append one byte to the line being built
	function automatic void add_byte(input logic [BYTE_W-1:0] b);
		line_buf = {line_buf, b};
	endfunction

	function automatic void put_text(input string s);
		foreach (s[i]) add_byte(s[i]);
	endfunction

	function automatic void put_line(input string s);
		put_text(s);
		add_byte(CH_NL);
	endfunction

	function automatic logic [BYTE_W-1:0] pick_blank();
		case ($urandom_range(0, 4))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VT;
			3: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	// decimal with optional blanks, sign and leading zero
	function automatic void put_number(input int v);
		string digits;
		int n;
		n = $urandom_range(0, 5);
		if (n >= 4) repeat (n - 3) add_byte(pick_blank());
		if (v < 0) begin
			add_byte(CH_MINUS);
			v = -v;
		end else if (v == 0 && $urandom_range(0, 4) == 0) begin
			// negative zero is a legal zero
			add_byte(CH_MINUS);
		end else if ($urandom_range(0, 7) == 0) begin
			add_byte(CH_PLUS);
		end
		if ($urandom_range(0, 7) == 0) add_byte(CH_0);
		digits = $sformatf("%0d", v);
		foreach (digits[i]) add_byte(digits[i]);
	endfunction

	// six hex digits, case picked per digit
	function automatic void put_hex(input logic [RGB_W-1:0] rgb);
		logic [3:0] nib;
		for (int i = 5; i >= 0; i--) begin
			nib = rgb[i*4 +: 4];
			if (nib < 4'd10) begin
				add_byte(CH_0 + nib);
			end else if ($urandom_range(0, 1) == 0) begin
				add_byte(CH_UA + nib - 8'd10);
			end else begin
				add_byte(CH_LA + nib - 8'd10);
			end
		end
	endfunction

	// junk after a complete command, never a newline
	function automatic void put_tail();
		logic [BYTE_W-1:0] b;
		repeat ($urandom_range(0, 3)) begin
			b = BYTE_W'($urandom_range(0, 254));
			if (b >= CH_NL) b++;
			add_byte(b);
		end
	endfunction

	function automatic void put_pixel(input int x, input int y, input logic [RGB_W-1:0] rgb);
		put_text("PX ");
		put_number(x);
		add_byte(CH_SPACE);
		put_number(y);
		add_byte(CH_SPACE);
		put_hex(rgb);
		put_tail();
		add_byte(CH_NL);
	endfunction

	function automatic void put_size();
		put_text("SIZE");
		put_tail();
		add_byte(CH_NL);
	endfunction

	// mostly in range, with the edges, saturation and negatives mixed in
	function automatic int pick_coord(input int bound);
		if (bound <= 0) return $urandom_range(0, 3);
		case ($urandom_range(0, 23))
			0: return bound - 1;
			1: return bound;
			2: return 4095;
			3: return 4096;
			4: return -int'($urandom_range(1, 20));
			5: return $urandom_range(5000, 2000000000);
			default: return $urandom_range(0, bound - 1);
		endcase
	endfunction

	function automatic void put_base();
		if ($urandom_range(0, 2) == 0) put_size();
		else put_pixel(pick_coord(cur_w), pick_coord(cur_h), RGB_W'($urandom));
	endfunction

	function automatic void put_random_line();
		int pick;
		int pos;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			put_pixel(pick_coord(cur_w), pick_coord(cur_h), RGB_W'($urandom));
		end else if (pick < 70) begin
			put_size();
		end else if (pick < 80) begin
			// one byte replaced by anything, newline included
			put_base();
			pos = $urandom_range(0, line_buf.size() - 2);
			line_buf[pos] = BYTE_W'($urandom_range(0, 255));
		end else if (pick < 88) begin
			// line cut short by an early newline
			put_base();
			pos = $urandom_range(1, line_buf.size() - 2);
			while (line_buf.size() > pos) void'(line_buf.pop_back());
			add_byte(CH_NL);
		end else if (pick < 95) begin
			repeat ($urandom_range(1, 8)) add_byte(BYTE_W'($urandom_range(0, 255)));
			add_byte(CH_NL);
		end else begin
			add_byte(CH_NL);
		end
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// offer one item and return at the edge that takes it; valid stays high
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (!tx_calm && !quiet_tail && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_line();
		foreach (line_buf[i]) send_byte(line_buf[i]);
		line_buf.delete();
	endtask

	// stop offering, wait for every reply due, then let the pipe empty
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both frame registers back to back, only while the parser is idle
	task automatic set_frame(input int w, input int h);
		cur_w = w;
		cur_h = h;
		cfg_valid <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= COORD_W'(w);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data <= COORD_W'(h);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	initial begin
		int unsigned target;
		tracker = new(COORD_BITS);
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines at the reset frame of 64 by 32
		put_line("SIZE");
		put_line("PX 0 0 000000");
		put_line("PX 63 31 FFffFF");
		put_line("PX 64 0 000000");                // column at the width
		put_line("PX 0 32 000000");                // row at the height
		put_text("PX ");                           // every skipped blank, signs, tail
		add_byte(CH_TAB);
		add_byte(CH_VT);
		add_byte(CH_FF);
		add_byte(CH_CR);
		put_line("+5  -0 aBcDeF zz");
		put_line("PX - 1 123456");                 // sign with no digits
		put_line("PX 99999999999 1 123456");       // saturating number
		put_line("PX 4096 1 123456");
		put_line("PX -3 1 123456");                // negative value
		put_line("PX 5x 1 123456");                // bad number terminator
		put_line("PX 1 2 12g456");                 // non-hex colour digit
		put_line("PX 1 2 123");                    // newline inside the colour
		put_line("PX 1 2");                        // newline ends the row number
		put_line("");                              // empty line
		put_line("QX 1 2");                        // bad first byte, rest dropped
		put_line("PX");                            // fault on the newline itself
		put_line("SIZE");
		put_text("S?");                            // dropped bytes at both extremes
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(CH_NL);
		put_line("SIZEXYZ");
		send_line();

		// a zero frame rejects every coordinate
		wait_drained();
		set_frame(0, 0);
		put_line("PX 0 0 000000");
		put_line("SIZE");
		send_line();

		// random phases, each under its own frame size
		for (int p = 0; p < 6; p++) begin
			wait_drained();
			case (p)
				0: set_frame(4096, 4096);
				1: set_frame(200, 100);
				2: set_frame(1, 1);
				3: set_frame(4096, 1);
				4: set_frame(1, 4096);
				default: set_frame($urandom_range(1, 4096), $urandom_range(1, 4096));
			endcase
			if (p == 1) begin
				// receiver holds off while pixel writes keep coming,
				// so the output fills and the byte side stalls
				rx_hold_req = HOLD_CYCLES;
				tx_calm = 1'b1;
				repeat (12) begin
					put_pixel($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
						RGB_W'($urandom));
					send_line();
				end
			end
			target = bytes_taken + PHASE_BYTES;
			while (bytes_taken < target) begin
				if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
				put_random_line();
				send_line();
			end
		end

		// last stretch at full rate on both sides
		quiet_tail = 1'b1;
		tx_calm = 1'b1;
		while (bytes_taken < RUN_BYTES) begin
			put_random_line();
			send_line();
		end

		wait_drained();
		if (tracker.failures == 0) begin
			$display("pixel_flood_command_parser_test passed");
		end else begin
			$display("pixel_flood_command_parser_test failed");
		end
		$finish;
	end

endmodule
